### rtl/gjll_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Gaussian joint log likelihood block.
// No dependencies; every other file imports this package.
package gjll_pkg;

    localparam int MAX_DIM_DEF   = 16;
    localparam int FRAC_BITS_DEF = 16;

    // ln(2*pi) with 32 fraction bits; rounded to nearest at FRAC_BITS where used
    localparam logic [63:0] LN2PI_Q32 = 64'd7893621894;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef enum logic [1:0] {
        OP_LOAD_DIFF = 2'd0,
        OP_LOAD_COV  = 2'd1,
        OP_COMPUTE   = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [3:0]          element_index;
        logic [3:0]          matrix_row;
        logic [3:0]          matrix_col;
        logic signed [31:0]  obs_value;
        logic signed [31:0]  mean_value;
        logic signed [31:0]  matrix_value;
        logic [4:0]          set_dim;
        logic signed [31:0]  log_cov_det;
        logic signed [31:0]  log_trans;
        logic                add_transition;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0]  log_joint_prob;
        logic                saturated;
    } result_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_TERM,
        MUL_LO,
        MUL_HI
    } mul_kind_t;

    typedef struct packed {
        mul_kind_t kind;
        logic      first;
    } mul_tag_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM,
        ST_GAP,
        ST_LO,
        ST_HI,
        ST_DRAIN,
        ST_CLAMP,
        ST_TOTAL,
        ST_OUT
    } state_t;

    // Saturate to 32 bits; bit 32 of the result is the clip flag
    function automatic logic [32:0] sat32(input logic signed [63:0] x);
        logic [32:0] r;
        if (x > SAT_MAX) begin
            r = {1'b1, SAT_MAX[31:0]};
        end else if (x < SAT_MIN) begin
            r = {1'b1, SAT_MIN[31:0]};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

endpackage

### rtl/gjll_store.sv
`timescale 1ns / 1ps
// Difference vector and inverse covariance memories with registered reads.
// Depends on gjll_pkg.
module gjll_store import gjll_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF,
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  cmd_t                cmd,
    input  logic [IDX_W-1:0]    diff_addr,
    input  logic [ADDR_W-1:0]   cov_addr,
    output logic signed [31:0]  rd_diff,
    output logic signed [31:0]  rd_cov
);

    logic signed [31:0] diff_mem [MAX_DIM];
    logic signed [31:0] cov_mem  [MAX_DIM * MAX_DIM];

    logic signed [31:0] rd_diff_reg;
    logic signed [31:0] rd_cov_reg;

    logic signed [63:0] diff_wide;
    logic [32:0]        diff_sat;
    logic               diff_ok;
    logic               cov_ok;
    logic [IDX_W-1:0]   diff_wa;
    logic [ADDR_W-1:0]  cov_wa;

    assign diff_wide = 64'(cmd.obs_value) - 64'(cmd.mean_value);
    assign diff_sat  = sat32(diff_wide);
    assign diff_ok   = 32'(cmd.element_index) < MAX_DIM;
    assign cov_ok    = (32'(cmd.matrix_row) < MAX_DIM) && (32'(cmd.matrix_col) < MAX_DIM);
    assign diff_wa   = IDX_W'(cmd.element_index);
    assign cov_wa    = ADDR_W'(32'(cmd.matrix_row) * MAX_DIM + 32'(cmd.matrix_col));

    // Drop loads whose index is beyond the store
    always_ff @(posedge clk) begin
        if (wr_en && cmd.opcode == OP_LOAD_DIFF && diff_ok) begin
            diff_mem[diff_wa] <= diff_sat[31:0];
        end
        if (wr_en && cmd.opcode == OP_LOAD_COV && cov_ok) begin
            cov_mem[cov_wa] <= cmd.matrix_value;
        end
    end

    always_ff @(posedge clk) begin
        rd_diff_reg <= diff_mem[diff_addr];
        rd_cov_reg  <= cov_mem[cov_addr];
    end

    assign rd_diff = rd_diff_reg;
    assign rd_cov  = rd_cov_reg;

endmodule

### rtl/gjll_mul.sv
`timescale 1ns / 1ps
// Shared 33x33 signed multiplier with operand select and registered product.
// Depends on gjll_pkg.
module gjll_mul import gjll_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  mul_tag_t            issue_tag,
    input  logic signed [31:0]  rd_diff,
    input  logic signed [31:0]  rd_cov,
    input  logic signed [63:0]  inner,
    output mul_tag_t            prod_tag,
    output logic signed [64:0]  product
);

    mul_tag_t           tag1_reg;
    mul_tag_t           tag2_reg;
    logic signed [64:0] product_reg;

    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [65:0] prod_full;

    // Inner sum is split into an unsigned low word and a signed high word
    always_comb begin
        case (tag1_reg.kind)
            MUL_TERM: op_a = {rd_cov[31], rd_cov};
            MUL_LO:   op_a = {1'b0, inner[31:0]};
            MUL_HI:   op_a = {inner[63], inner[63:32]};
            default:  op_a = '0;
        endcase
    end

    assign op_b      = {rd_diff[31], rd_diff};
    assign prod_full = op_a * op_b;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tag1_reg <= '{kind: MUL_NONE, first: 1'b0};
            tag2_reg <= '{kind: MUL_NONE, first: 1'b0};
        end else begin
            tag1_reg <= issue_tag;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk) begin
        product_reg <= prod_full[64:0];
    end

    assign prod_tag = tag2_reg;
    assign product  = product_reg;

endmodule

### rtl/gjll_ctrl.sv
`timescale 1ns / 1ps
// Sequencer, accumulators and final scaling and saturation of the log density.
// Depends on gjll_pkg.
module gjll_ctrl import gjll_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1,
    localparam int DIM_W  = $clog2(MAX_DIM + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cmd_t                cmd,
    output logic                busy,
    output logic [IDX_W-1:0]    diff_addr,
    output logic [ADDR_W-1:0]   cov_addr,
    output mul_tag_t            issue_tag,
    output logic signed [63:0]  inner,
    input  mul_tag_t            prod_tag,
    input  logic signed [64:0]  product,
    output logic                done,
    output result_t             result
);

    localparam logic [63:0] LN2PI_Q =
        (LN2PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [127:0] QUAD_LIM   = 128'sd1 <<< 62;
    localparam logic signed [63:0]  QUAD_LIM64 = 64'sd1 <<< 62;

    state_t             state_reg, state_next;
    logic [DIM_W-1:0]   i_reg, i_next;
    logic [DIM_W-1:0]   j_reg, j_next;
    logic               drain_reg, drain_next;
    logic               done_reg, done_next;

    logic [DIM_W-1:0]   dim_reg;
    logic signed [31:0] logdet_reg;
    logic signed [31:0] trans_reg;
    logic               add_reg;
    logic signed [63:0] inner_reg;
    logic signed [127:0] acc_reg;
    logic signed [63:0] quad_reg;
    logic signed [63:0] total_reg;
    result_t            result_reg;

    logic               accept_compute;
    logic [DIM_W-1:0]   dim_in;
    logic [DIM_W-1:0]   dim_last;
    logic signed [63:0] term;
    logic signed [127:0] shifted;
    logic signed [63:0] quad_next;
    logic signed [63:0] dim_term;
    logic signed [63:0] total_next;
    logic signed [63:0] neg_total;
    logic signed [63:0] half;
    logic signed [63:0] sum;
    logic [32:0]        sat_out;

    assign accept_compute = start && !busy && cmd.opcode == OP_COMPUTE;
    assign dim_in   = (32'(cmd.set_dim) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cmd.set_dim);
    assign dim_last = DIM_W'(dim_reg - 1'b1);
    assign busy     = state_reg != ST_IDLE;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            drain_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            drain_reg <= drain_next;
            done_reg  <= done_next;
        end
    end

    // Per row: dim term reads, one gap for the inner sum to settle, then low and high halves
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        drain_next = drain_reg;
        done_next  = 1'b0;
        issue_tag  = '{kind: MUL_NONE, first: 1'b0};
        diff_addr  = j_reg[IDX_W-1:0];
        cov_addr   = ADDR_W'(32'(j_reg) * MAX_DIM + 32'(i_reg));
        case (state_reg)
            ST_IDLE: begin
                if (accept_compute) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = (dim_in == '0) ? ST_CLAMP : ST_TERM;
                end
            end
            ST_TERM: begin
                issue_tag = '{kind: MUL_TERM, first: (j_reg == '0)};
                if (j_reg == dim_last) begin
                    j_next     = '0;
                    state_next = ST_GAP;
                end else begin
                    j_next = DIM_W'(j_reg + 1'b1);
                end
            end
            ST_GAP: begin
                state_next = ST_LO;
            end
            ST_LO: begin
                diff_addr  = i_reg[IDX_W-1:0];
                issue_tag  = '{kind: MUL_LO, first: 1'b0};
                state_next = ST_HI;
            end
            ST_HI: begin
                diff_addr = i_reg[IDX_W-1:0];
                issue_tag = '{kind: MUL_HI, first: 1'b0};
                if (i_reg == dim_last) begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end else begin
                    i_next     = DIM_W'(i_reg + 1'b1);
                    state_next = ST_TERM;
                end
            end
            ST_DRAIN: begin
                // Wait for the last product to land in the accumulator
                if (drain_reg) begin
                    state_next = ST_CLAMP;
                end else begin
                    drain_next = 1'b1;
                end
            end
            ST_CLAMP: begin
                state_next = ST_TOTAL;
            end
            ST_TOTAL: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign term    = $signed(product[63:0]) >>> FRAC_BITS;
    assign shifted = acc_reg >>> FRAC_BITS;

    always_comb begin
        if (shifted > QUAD_LIM) begin
            quad_next = QUAD_LIM64;
        end else if (shifted < -QUAD_LIM) begin
            quad_next = -QUAD_LIM64;
        end else begin
            quad_next = shifted[63:0];
        end
    end

    assign dim_term   = $signed(64'(dim_reg) * LN2PI_Q);
    assign total_next = dim_term + 64'(logdet_reg) + quad_reg;
    assign neg_total  = -total_reg;
    assign half       = neg_total >>> 1;
    assign sum        = half + (add_reg ? 64'(trans_reg) : 64'sd0);
    assign sat_out    = sat32(sum);

    always_ff @(posedge clk) begin
        if (accept_compute) begin
            dim_reg    <= dim_in;
            logdet_reg <= cmd.log_cov_det;
            trans_reg  <= cmd.log_trans;
            add_reg    <= cmd.add_transition;
            acc_reg    <= '0;
        end else begin
            case (prod_tag.kind)
                MUL_TERM: inner_reg <= prod_tag.first ? term : inner_reg + term;
                MUL_LO:   acc_reg   <= acc_reg + {{63{product[64]}}, product};
                MUL_HI:   acc_reg   <= acc_reg + {{32{product[63]}}, product[63:0], 32'd0};
                default:  acc_reg   <= acc_reg;
            endcase
        end
        if (state_reg == ST_CLAMP) begin
            quad_reg <= quad_next;
        end
        if (state_reg == ST_TOTAL) begin
            total_reg <= total_next;
        end
        if (state_reg == ST_OUT) begin
            result_reg.log_joint_prob <= sat_out[31:0];
            result_reg.saturated      <= sat_out[32];
        end
    end

    assign inner  = inner_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/gaussian_joint_log_likelihood.sv
`timescale 1ns / 1ps
// Gaussian joint log likelihood unit: top level.
// Depends on gjll_pkg, gjll_store, gjll_mul and gjll_ctrl.
//
// Usage: drive an item on cmd with start high; it is taken at a rising edge
// where busy is low. Opcode 0 stores obs_value - mean_value (saturated) at
// element_index, opcode 1 stores matrix_value at (matrix_row, matrix_col);
// both finish in the accepting cycle and never raise busy. Opcode 3 is dropped.
// Opcode 2 computes the log density and raises busy until the result is ready;
// dim is set_dim clipped to MAX_DIM, and dim zero skips the quadratic form. Each row of
// the quadratic form runs dim inner products, a settling gap and two
// partial products through the single shared multiplier, which sets the rate.
// The result appears on result with done high for one cycle, as busy falls;
// it must be taken then, since the receiver cannot stall it.
// Loads are one item per cycle; after a compute item the next item is taken
// only once busy is low again.
// Reset clears the sequencer and the done strobe; store contents are kept
// undefined until loaded, and compute must only read loaded entries.
module gaussian_joint_log_likelihood import gjll_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    logic [IDX_W-1:0]   diff_addr;
    logic [ADDR_W-1:0]  cov_addr;
    logic signed [31:0] rd_diff;
    logic signed [31:0] rd_cov;
    logic signed [63:0] inner;
    logic signed [64:0] product;
    mul_tag_t           issue_tag;
    mul_tag_t           prod_tag;
    logic               wr_en;

    assign wr_en = start && !busy;

    gjll_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .cmd       (cmd),
        .diff_addr (diff_addr),
        .cov_addr  (cov_addr),
        .rd_diff   (rd_diff),
        .rd_cov    (rd_cov)
    );

    gjll_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue_tag (issue_tag),
        .rd_diff   (rd_diff),
        .rd_cov    (rd_cov),
        .inner     (inner),
        .prod_tag  (prod_tag),
        .product   (product)
    );

    gjll_ctrl #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .diff_addr (diff_addr),
        .cov_addr  (cov_addr),
        .issue_tag (issue_tag),
        .inner     (inner),
        .prod_tag  (prod_tag),
        .product   (product),
        .done      (done),
        .result    (result)
    );

endmodule

### rtl/gjll_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the Gaussian joint log likelihood unit, bound to the top level.
// Depends on gjll_pkg and gaussian_joint_log_likelihood.
module gjll_checker import gjll_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input cmd_t    cmd,
    input logic    busy,
    input logic    done,
    input result_t result
);

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.opcode == OP_COMPUTE) |=> busy)
        else $error("compute item did not raise busy");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.opcode != OP_COMPUTE) |=> (!busy && !done))
        else $error("load item raised busy or gave a result");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturated) |->
            (result.log_joint_prob == 32'h7FFF_FFFF ||
             result.log_joint_prob == 32'h8000_0000))
        else $error("saturated result not at a range limit");

endmodule

bind gaussian_joint_log_likelihood gjll_checker u_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_joint_log_likelihood: compute results are checked
// against a local fixed-point predictor fed by the loads. Depends on gjll_pkg and the block.
module tb;
    import gjll_pkg::*;

    localparam int         DIM_CAP       = 16;
    localparam int         FRAC          = 16;
    localparam logic [1:0] OP_IGNORED    = 2'd3;
    localparam longint     LN_TWO_PI_Q32 = 64'sd7893621894;
    localparam longint     LN_TWO_PI     = (LN_TWO_PI_Q32 + (64'sd1 <<< (31 - FRAC)))
                                           >>> (32 - FRAC);
    localparam longint     QUAD_CLAMP    = 64'sd1 <<< 62;
    localparam int         INT_MAX       = 32'h7fffffff;
    localparam int         INT_MIN       = 32'h80000000;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         ITEM_TARGET   = 650;
    localparam int         RESULT_TARGET = 60;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    cmd_t    pending_items[$];
    result_t expected_results[$];
    result_t due;

    // predictor copy of the stores
    int diff_vec[DIM_CAP];
    int inv_cov[DIM_CAP][DIM_CAP];

    // generator bookkeeping: which entries have been written at least once
    bit diff_loaded[DIM_CAP];
    bit cov_loaded[DIM_CAP][DIM_CAP];

    int total_items     = 0;
    int accepted_items  = 0;
    int ignored_queued  = 0;
    int computes_queued = 0;
    int mismatches      = 0;
    int burst_left      = 0;
    int gap_left        = 0;
    int idle_cycles     = 0;
    bit diff_clipped;

    gaussian_joint_log_likelihood DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int clip32(input longint x, output bit clipped);
        clipped = 1'b1;
        if (x > longint'(INT_MAX))
            return INT_MAX;
        if (x < longint'(INT_MIN))
            return INT_MIN;
        clipped = 1'b0;
        return int'(x);
    endfunction

    function automatic result_t log_density(cmd_t c);
        int                  dim;
        longint              inner;
        longint              quad;
        longint              total;
        longint              half;
        logic signed [127:0] acc;
        logic signed [127:0] wide_inner;
        logic signed [127:0] wide_diff;
        logic signed [127:0] scaled;
        bit                  clipped;
        result_t             r;
        dim = (c.set_dim > DIM_CAP) ? DIM_CAP : int'(c.set_dim);
        acc = '0;
        for (int i = 0; i < dim; i++)
        begin
            inner = 0;
            // each term is floored on its own before the row sum
            for (int j = 0; j < dim; j++)
                inner += (longint'(diff_vec[j]) * longint'(inv_cov[j][i])) >>> FRAC;
            wide_inner = inner;
            wide_diff  = diff_vec[i];
            acc        = acc + wide_inner * wide_diff;
        end
        scaled = acc >>> FRAC;
        if (scaled > QUAD_CLAMP)
            quad = QUAD_CLAMP;
        else if (scaled < -QUAD_CLAMP)
            quad = -QUAD_CLAMP;
        else
            quad = longint'(scaled);
        total = longint'(dim) * LN_TWO_PI + longint'($signed(c.log_cov_det)) + quad;
        half  = (-total) >>> 1;
        if (c.add_transition)
            half += longint'($signed(c.log_trans));
        r.log_joint_prob = clip32(half, clipped);
        r.saturated      = clipped;
        return r;
    endfunction

    function automatic cmd_t scrambled_cmd();
        logic [191:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return noise[$bits(cmd_t)-1:0];
    endfunction

    function automatic int tame_value();
        return int'($urandom_range(0, 524288)) - 262144;
    endfunction

    function automatic int any_value();
        case ($urandom_range(0, 7))
            0: return INT_MAX;
            1: return INT_MIN;
            2: return 0;
            3, 4: return $urandom;
            default: return tame_value();
        endcase
    endfunction

    function automatic int trans_value();
        case ($urandom_range(0, 7))
            0: return INT_MIN;
            1: return 0;
            2: return $urandom;
            default: return -int'($urandom_range(0, 2097152));
        endcase
    endfunction

    task automatic queue_diff(int idx, int obs, int mean);
        cmd_t c;
        c               = scrambled_cmd();
        c.opcode        = OP_LOAD_DIFF;
        c.element_index = 4'(idx);
        c.obs_value     = obs;
        c.mean_value    = mean;
        pending_items.push_back(c);
        diff_loaded[idx] = 1'b1;
    endtask

    task automatic queue_cov(int row, int col, int value);
        cmd_t c;
        c              = scrambled_cmd();
        c.opcode       = OP_LOAD_COV;
        c.matrix_row   = 4'(row);
        c.matrix_col   = 4'(col);
        c.matrix_value = value;
        pending_items.push_back(c);
        cov_loaded[row][col] = 1'b1;
    endtask

    task automatic queue_compute(int dim, int det, int trans, bit add);
        cmd_t c;
        c                = scrambled_cmd();
        c.opcode         = OP_COMPUTE;
        c.set_dim        = 5'(dim);
        c.log_cov_det    = det;
        c.log_trans      = trans;
        c.add_transition = add;
        pending_items.push_back(c);
        computes_queued++;
    endtask

    task automatic queue_ignored();
        cmd_t c;
        c        = scrambled_cmd();
        c.opcode = OP_IGNORED;
        pending_items.push_back(c);
        ignored_queued++;
    endtask

    // driver: hold the item while busy, otherwise launch the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                case (cmd.opcode)
                    OP_LOAD_DIFF:
                        diff_vec[cmd.element_index] =
                            clip32(longint'($signed(cmd.obs_value)) -
                                   longint'($signed(cmd.mean_value)), diff_clipped);
                    OP_LOAD_COV:
                        inv_cov[cmd.matrix_row][cmd.matrix_col] = cmd.matrix_value;
                    OP_COMPUTE:
                        expected_results.push_back(log_density(cmd));
                    default: ;
                endcase
                accepted_items++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0 || pending_items.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    start <= 1'b0;
                end
                else
                begin
                    start <= 1'b1;
                    cmd   <= pending_items.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            3:       gap_left = $urandom_range(10, 60);
                            default: gap_left = $urandom_range(1, 8);
                        endcase
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: log_joint_prob %0d, saturated %0b",
                       result.log_joint_prob, result.saturated);
                mismatches++;
            end
            else
            begin
                due = expected_results.pop_front();
                if (result.log_joint_prob !== due.log_joint_prob)
                begin
                    $error("log_joint_prob: expected %0d, actual %0d",
                           due.log_joint_prob, result.log_joint_prob);
                    mismatches++;
                end
                if (result.saturated !== due.saturated)
                begin
                    $error("saturated: expected %0b, actual %0b",
                           due.saturated, result.saturated);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        int  dim;
        int  span;
        int  seq;
        bit  wild;

        // zero dimension: only the determinant and transition terms remain
        queue_compute(0, 0, 0, 1'b0);
        queue_compute(0, INT_MIN, INT_MAX, 1'b1);
        queue_compute(0, INT_MAX, INT_MIN, 1'b1);
        queue_ignored();
        // difference overflow both ways, large quadratic form of both signs
        queue_diff(0, INT_MAX, INT_MIN);
        queue_cov(0, 0, INT_MAX);
        queue_compute(1, 0, 0, 1'b0);
        queue_diff(0, INT_MIN, INT_MAX);
        queue_cov(0, 0, INT_MIN);
        queue_compute(1, INT_MAX, -65536, 1'b1);
        // small well-behaved 2x2 case with negative terms to floor
        queue_diff(0, 32'h18000, 32'h8000);
        queue_diff(1, -32'h8000, 0);
        queue_cov(0, 0, 32'h10000);
        queue_cov(0, 1, 3);
        queue_cov(1, 0, -3);
        queue_cov(1, 1, 32'h10000);
        queue_compute(2, 0, -65536, 1'b1);
        queue_compute(2, -131072, 65536, 1'b1);

        seq = 0;
        while (pending_items.size() - ignored_queued < ITEM_TARGET ||
               computes_queued < RESULT_TARGET)
        begin
            wild = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0:       dim = $urandom_range(0, 31);
                1, 2:    dim = $urandom_range(5, 16);
                default: dim = $urandom_range(1, 4);
            endcase
            // force one oversized set early so the whole store gets filled
            if (seq == 2)
                dim = $urandom_range(17, 31);
            span = (dim > DIM_CAP) ? DIM_CAP : dim;
            for (int j = 0; j < span; j++)
                if (!diff_loaded[j] || $urandom_range(0, 2) == 0)
                    queue_diff(j, wild ? any_value() : tame_value(),
                               wild ? any_value() : tame_value());
            for (int r = 0; r < span; r++)
                for (int k = 0; k < span; k++)
                    if (!cov_loaded[r][k] || $urandom_range(0, 7) == 0)
                        queue_cov(r, k, wild ? any_value() : tame_value());
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: queue_diff($urandom_range(0, DIM_CAP - 1), any_value(), any_value());
                    1: queue_cov($urandom_range(0, DIM_CAP - 1),
                                 $urandom_range(0, DIM_CAP - 1), any_value());
                    default: queue_ignored();
                endcase
            end
            queue_compute(dim, wild ? any_value() : tame_value(), trans_value(),
                          1'($urandom_range(0, 1)));
            seq++;
        end
        total_items = pending_items.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_items < total_items)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
rtl/gjll_pkg.sv
rtl/gjll_store.sv
rtl/gjll_mul.sv
rtl/gjll_ctrl.sv
rtl/gaussian_joint_log_likelihood.sv
rtl/gjll_checker.sv
tb/tb.sv
